// ----- rtl/core/oqpsk_pkg.sv -----
package oqpsk_pkg;

    localparam int SPC_DEFAULT         = 8;
    localparam int SAMPLE_BITS_DEFAULT = 12;
    localparam int OUT_W               = 12;
    localparam int SYM_W               = 4;

    localparam logic [3:0] PAIR_LAST = 4'd15;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_SAMPLE      = 2'd0,
        KIND_LOAD_OK     = 2'd1,
        KIND_LOAD_REJECT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               symbol_start;
        logic [OUT_W-1:0]   q_sample;
        logic [OUT_W-1:0]   i_sample;
    } t_result;

    // chip 0 in bit 31
    localparam logic [31:0] CHIP_TABLE [16] = '{
        32'hD9C3522E, 32'hED9C3522, 32'h2ED9C352, 32'h22ED9C35,
        32'h522ED9C3, 32'h3522ED9C, 32'hC3522ED9, 32'h9C3522ED,
        32'h8C96077B, 32'hB8C96077, 32'h7B8C9607, 32'h77B8C960,
        32'h077B8C96, 32'h6077B8C9, 32'h96077B8C, 32'hC96077B8
    };

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // q30 taylor sine, clamped to [0, 1], scaled by amp with rounding
    function automatic logic [63:0] sine_mag(input logic [63:0] theta,
                                             input logic [63:0] amp);
        logic [63:0]        t2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        t2   = (theta * theta) >> 30;
        term = theta;
        sum  = signed'(theta);
        term = ((term * t2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * t2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * t2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * t2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * t2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        term = ((term * t2) >> 30) / 64'd156;
        sum  = sum + signed'(term);
        term = ((term * t2) >> 30) / 64'd210;
        sum  = sum - signed'(term);
        if (sum < 0) begin
            sum = '0;
        end
        if (sum > signed'(ONE_Q30)) begin
            sum = signed'(ONE_Q30);
        end
        return (amp * unsigned'(sum) + (64'd1 << 29)) >> 30;
    endfunction

endpackage

// ----- rtl/core/oqpsk_pulse.sv -----
module oqpsk_pulse #(
    parameter int SPC         = oqpsk_pkg::SPC_DEFAULT,
    parameter int SAMPLE_BITS = oqpsk_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                         i_en,
    input  logic                         i_chip,
    input  logic [$clog2(2*SPC)-1:0]     i_pos,
    output logic [oqpsk_pkg::OUT_W-1:0]  o_sample
);

    localparam int POS_W = $clog2(2*SPC);
    localparam int Q_W   = $clog2(SPC+1);
    localparam int MAG_W = SAMPLE_BITS - 1;
    localparam int EXT_W = (SAMPLE_BITS > oqpsk_pkg::OUT_W) ? SAMPLE_BITS : oqpsk_pkg::OUT_W;
    localparam logic [63:0] AMP = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    logic [MAG_W-1:0] mag_rom [SPC+1];

    for (genvar g = 0; g <= SPC; g++) begin : g_rom
        localparam logic [63:0] THETA = (oqpsk_pkg::HALF_PI_Q30 * 64'(g)) / 64'(SPC);
        assign mag_rom[g] = MAG_W'(oqpsk_pkg::sine_mag(THETA, AMP));
    end

    logic [Q_W-1:0]   q;
    logic [EXT_W-1:0] mag_ext;
    logic [EXT_W-1:0] val;

    // distance to the nearer pulse end
    always_comb begin
        if (i_pos <= POS_W'(SPC)) begin
            q = Q_W'(i_pos);
        end else begin
            q = Q_W'((POS_W+1)'(2*SPC) - {1'b0, i_pos});
        end
        mag_ext  = EXT_W'(mag_rom[q]);
        val      = i_chip ? mag_ext : (EXT_W'(0) - mag_ext);
        o_sample = i_en ? val[oqpsk_pkg::OUT_W-1:0] : '0;
    end

endmodule

// ----- rtl/core/oqpsk_seq.sv -----
module oqpsk_seq #(
    parameter int SPC         = oqpsk_pkg::SPC_DEFAULT,
    parameter int SAMPLE_BITS = oqpsk_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_command,
    input  logic [oqpsk_pkg::SYM_W-1:0]   i_symbol,
    output oqpsk_pkg::t_result            o_result
);

    localparam int POS_W = $clog2(2*SPC);
    localparam logic [POS_W-1:0] POS_SPC       = POS_W'(SPC);
    localparam logic [POS_W-1:0] POS_HALF_LAST = POS_W'(SPC - 1);
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(2*SPC - 1);

    logic [31:0]                   r_chip_word;
    logic [oqpsk_pkg::SYM_W-1:0]   r_pend_sym;
    logic                          r_pend_valid;
    logic [3:0]                    r_pair;
    logic [POS_W-1:0]              r_pos;
    logic                          r_active;
    logic                          r_last_q_chip;
    logic                          r_last_q_valid;

    logic                          tick;
    logic                          start_now;
    logic                          eff_active;
    logic [31:0]                   eff_word;
    logic                          pos_hi;
    logic [3:0]                    q_pair;
    logic                          q_use_last;
    logic                          i_en;
    logic                          q_en;
    logic                          i_chip;
    logic                          q_chip;
    logic [POS_W-1:0]              q_pos;
    logic [oqpsk_pkg::OUT_W-1:0]   i_val;
    logic [oqpsk_pkg::OUT_W-1:0]   q_val;

    always_comb begin
        tick       = (i_command == oqpsk_pkg::CMD_TICK);
        start_now  = tick && !r_active && r_pend_valid &&
                     (!r_last_q_valid || (r_pos == '0 && r_pair == '0));
        eff_active = r_active || start_now;
        eff_word   = start_now ? oqpsk_pkg::CHIP_TABLE[r_pend_sym] : r_chip_word;
        pos_hi     = (r_pos >= POS_SPC);
        q_pair     = pos_hi ? r_pair : (r_pair - 4'd1);
        q_pos      = pos_hi ? (r_pos - POS_SPC) : (r_pos + POS_SPC);
        q_use_last = !eff_active || (!pos_hi && r_pair == '0);
        i_chip     = eff_word[{~r_pair, 1'b1}];
        q_chip     = q_use_last ? r_last_q_chip : eff_word[{~q_pair, 1'b0}];
        i_en       = tick && eff_active;
        q_en       = tick && (q_use_last ? r_last_q_valid : 1'b1);

        o_result.i_sample     = i_val;
        o_result.q_sample     = q_val;
        o_result.symbol_start = tick && eff_active && r_pos == '0 && r_pair == '0;
        if (tick) begin
            o_result.kind = oqpsk_pkg::KIND_SAMPLE;
        end else if (r_pend_valid) begin
            o_result.kind = oqpsk_pkg::KIND_LOAD_REJECT;
        end else begin
            o_result.kind = oqpsk_pkg::KIND_LOAD_OK;
        end
    end

    oqpsk_pulse #(
        .SPC         (SPC),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_pulse_i (
        .i_en     (i_en),
        .i_chip   (i_chip),
        .i_pos    (r_pos),
        .o_sample (i_val)
    );

    oqpsk_pulse #(
        .SPC         (SPC),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_pulse_q (
        .i_en     (q_en),
        .i_chip   (q_chip),
        .i_pos    (q_pos),
        .o_sample (q_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid   <= 1'b0;
            r_pair         <= '0;
            r_pos          <= '0;
            r_active       <= 1'b0;
            r_last_q_valid <= 1'b0;
        end else if (i_step) begin
            if (!tick) begin
                if (!r_pend_valid) begin
                    r_pend_sym   <= i_symbol;
                    r_pend_valid <= 1'b1;
                end
            end else begin
                if (start_now) begin
                    r_chip_word  <= eff_word;
                    r_pend_valid <= 1'b0;
                    r_active     <= 1'b1;
                end
                if (eff_active) begin
                    if (r_pair == '0 && r_pos == POS_HALF_LAST) begin
                        r_last_q_valid <= 1'b0;
                    end
                    if (r_pair == oqpsk_pkg::PAIR_LAST && r_pos == POS_LAST) begin
                        r_last_q_chip  <= eff_word[0];
                        r_last_q_valid <= 1'b1;
                        r_active       <= 1'b0;
                        r_pos          <= '0;
                        r_pair         <= '0;
                    end else if (r_pos == POS_LAST) begin
                        r_pos  <= '0;
                        r_pair <= r_pair + 4'd1;
                    end else begin
                        r_pos <= r_pos + POS_W'(1);
                    end
                end else if (r_last_q_valid) begin
                    // trailing quadrature tail
                    if (r_pos == POS_HALF_LAST) begin
                        r_last_q_valid <= 1'b0;
                        r_pos          <= '0;
                    end else begin
                        r_pos <= r_pos + POS_W'(1);
                    end
                end
            end
        end
    end

endmodule

// ----- rtl/core/oqpsk_half_sine_chip_modulator.sv -----
// channel  dir  tdata                            tuser
// s_axis   in   [3:0] symbol                     [0] command (0 load, 1 tick)
// m_axis   out  [11:0] i_sample, [23:12] q_sample [1:0] kind, [2] symbol_start
//
// one transaction per cycle in while the output is not stalled, one result per transaction out
// the output register is loaded with the result of an input transaction as it is accepted
// a symbol lasts 32*SPC ticks, the last q chip tail SPC more
// synchronous active-low reset clears slot, counters and output valid
// output stall holds the register; input is taken when it is empty or draining
module oqpsk_half_sine_chip_modulator #(
    parameter int SPC         = oqpsk_pkg::SPC_DEFAULT,
    parameter int SAMPLE_BITS = oqpsk_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [3:0] symbol, [7:4] zero
    input  logic         s_axis_tuser,   // [0] command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,   // [11:0] i_sample, [23:12] q_sample
    output logic [2:0]   m_axis_tuser    // [1:0] kind, [2] symbol_start
);

    oqpsk_pkg::t_result result;
    oqpsk_pkg::t_result r_out;
    logic               r_out_valid;
    logic               step;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    oqpsk_seq #(
        .SPC         (SPC),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_command (s_axis_tuser),
        .i_symbol  (s_axis_tdata[oqpsk_pkg::SYM_W-1:0]),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
            r_out       <= result;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.q_sample, r_out.i_sample};
    assign m_axis_tuser  = {r_out.symbol_start, r_out.kind};

endmodule
